// File: rtl/core/sorted_matrix_search_top_defines.svh
// Assertion macros for the sorted matrix search block.
// Used by sorted_matrix_search_top; expects clk_i and rst_ni in scope.
`ifndef SORTED_MATRIX_SEARCH_TOP_DEFINES_SVH
`define SORTED_MATRIX_SEARCH_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define SMS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sorted_matrix_search assertion failed");
`define SMS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted_matrix_search assertion failed");
`else
`define SMS_ASSERT(lbl, prop)
`define SMS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/core/sms_pkg.sv
// Shared types, sizes and codes for the sorted matrix search block.
// No dependencies; sms_if, sms_cfg, sms_search and the top level refer to it.
`timescale 1ns / 1ps
`default_nettype none
package sms_pkg;

  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLS    = 64;
  localparam int STACK_DEPTH = 32;

  localparam int FIELD_W = 6;
  localparam int DATA_W  = 32;
  localparam int CNT_W   = 7;
  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int ADDR_W  = $clog2(MAX_ROWS * MAX_COLS);
  localparam int SP_W    = $clog2(STACK_DEPTH);
  localparam int LVL_W   = $clog2(STACK_DEPTH + 1);
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [CNT_W-1:0] ROW_COUNT_RST = CNT_W'(64);
  localparam logic [CNT_W-1:0] COL_COUNT_RST = CNT_W'(64);

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic {
    REG_ROW_COUNT = 1'b0,
    REG_COL_COUNT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [ROW_W-1:0] ai;
    logic [COL_W-1:0] aj;
    logic [ROW_W-1:0] zi;
    logic [COL_W-1:0] zj;
  } region_t;

  typedef struct packed {
    logic [CNT_W-1:0] row_count;
    logic [CNT_W-1:0] col_count;
  } cfg_t;

  typedef struct packed {
    logic             busy;
    logic [LVL_W-1:0] level;
  } status_t;

  function automatic logic [ADDR_W-1:0] addr_of(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
    return ADDR_W'(int'(r) * MAX_COLS + int'(c));
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/sms_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on sms_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface sms_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  cmd;
  logic        [sms_pkg::FIELD_W-1:0]    row;
  logic        [sms_pkg::FIELD_W-1:0]    col;
  logic signed [sms_pkg::DATA_W-1:0]     value;
  logic signed [sms_pkg::DATA_W-1:0]     target;

  modport source (output valid, cmd, row, col, value, target, input ready);
  modport sink   (input valid, cmd, row, col, value, target, output ready);
endinterface

interface sms_out_if;
  logic valid;
  logic ready;
  logic found;

  modport source (output valid, found, input ready);
  modport sink   (input valid, found, output ready);
endinterface
`default_nettype wire

// File: rtl/core/sms_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module sms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// File: rtl/core/sms_cfg.sv
// APB register file holding row_count and col_count.
// Depends on sms_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sms_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [sms_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [sms_pkg::PDATA_W-1:0]  pwdata,
  output logic      [sms_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready,
  output sms_pkg::cfg_t                     cfg_o
);

  sms_pkg::cfg_t     cfg_q, cfg_d;
  sms_pkg::reg_idx_e idx;
  logic              wr_en;

  assign idx    = sms_pkg::reg_idx_e'(paddr[2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        sms_pkg::REG_ROW_COUNT: cfg_d.row_count = pwdata[sms_pkg::CNT_W-1:0];
        sms_pkg::REG_COL_COUNT: cfg_d.col_count = pwdata[sms_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      sms_pkg::REG_ROW_COUNT: prdata = sms_pkg::PDATA_W'(cfg_q.row_count);
      sms_pkg::REG_COL_COUNT: prdata = sms_pkg::PDATA_W'(cfg_q.col_count);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_count <= sms_pkg::ROW_COUNT_RST;
      cfg_q.col_count <= sms_pkg::COL_COUNT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/sms_search.sv
// Load/query sequencer: matrix RAM, region stack RAM and the
// quadrant-elimination state machine. Depends on sms_pkg, sms_if, sms_ram.
`timescale 1ns / 1ps
`default_nettype none
module sms_search (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  sms_pkg::cfg_t      cfg_i,
  sms_in_if.sink             req,
  sms_out_if.source          res,
  output sms_pkg::status_t   stat_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_POP, S_POPW, S_RA, S_RZ, S_CZ, S_C2, S_C3, S_CM,
    S_PU1, S_PU2, S_PU3, S_DONE
  } state_e;

  localparam int RW = sms_pkg::ROW_W;
  localparam int CW = sms_pkg::COL_W;

  function automatic logic [RW-1:0] last_row(logic [sms_pkg::CNT_W-1:0] n);
    int v;
    v = int'(n);
    if (v == 0) v = 1;
    if (v > sms_pkg::MAX_ROWS) v = sms_pkg::MAX_ROWS;
    return RW'(v - 1);
  endfunction

  function automatic logic [CW-1:0] last_col(logic [sms_pkg::CNT_W-1:0] n);
    int v;
    v = int'(n);
    if (v == 0) v = 1;
    if (v > sms_pkg::MAX_COLS) v = sms_pkg::MAX_COLS;
    return CW'(v - 1);
  endfunction

  state_e                          state_q;
  logic signed [sms_pkg::DATA_W-1:0] tgt_q, a_q;
  sms_pkg::region_t                rg_q;
  logic                            lt_q;
  logic                            found_q;
  logic [sms_pkg::LVL_W-1:0]       level_q, lvl_dec;
  logic                            out_valid_q, out_found_q;

  logic                            mem_we;
  logic [sms_pkg::ADDR_W-1:0]      mem_waddr, mem_raddr;
  logic [sms_pkg::DATA_W-1:0]      mem_rdata;
  logic signed [sms_pkg::DATA_W-1:0] rv;

  logic                            stk_we;
  logic [sms_pkg::SP_W-1:0]        stk_raddr;
  sms_pkg::region_t                stk_wdata, stk_rdata;

  logic [RW:0]                     isum;
  logic [CW:0]                     jsum;
  logic [RW-1:0]                   mi;
  logic [CW-1:0]                   mj;
  logic                            small_rg, stk_full, ll_ok, ur_ok;
  sms_pkg::region_t                diag_rg, ll_rg, ur_rg;
  logic                            accept;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state_q == S_IDLE);
  assign res.valid = out_valid_q;
  assign res.found = out_found_q;
  assign stat_o.busy  = (state_q != S_IDLE);
  assign stat_o.level = level_q;

  assign rv      = $signed(mem_rdata);
  assign lvl_dec = level_q - 1'b1;

  assign isum = {1'b0, rg_q.ai} + {1'b0, rg_q.zi};
  assign jsum = {1'b0, rg_q.aj} + {1'b0, rg_q.zj};
  assign mi   = isum[RW:1];
  assign mj   = jsum[CW:1];

  assign small_rg = ({1'b0, rg_q.zi} <= {1'b0, rg_q.ai} + 1'b1) &&
                    ({1'b0, rg_q.zj} <= {1'b0, rg_q.aj} + 1'b1);
  assign stk_full = (level_q >= sms_pkg::LVL_W'(sms_pkg::STACK_DEPTH));
  assign ll_ok    = (mi < rg_q.zi) && (mj > rg_q.aj);
  assign ur_ok    = (mi > rg_q.ai) && (mj < rg_q.zj);

  assign diag_rg = lt_q ? '{ai: rg_q.ai, aj: rg_q.aj, zi: mi, zj: mj}
                        : '{ai: mi, aj: mj, zi: rg_q.zi, zj: rg_q.zj};
  assign ll_rg   = '{ai: mi + 1'b1, aj: rg_q.aj, zi: rg_q.zi, zj: mj - 1'b1};
  assign ur_rg   = '{ai: rg_q.ai, aj: mj + 1'b1, zi: mi - 1'b1, zj: rg_q.zj};

  // matrix write on load
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sms_pkg::addr_of(RW'(req.row), CW'(req.col));
    if (accept && req.cmd == sms_pkg::CMD_LOAD &&
        int'(req.row) < sms_pkg::MAX_ROWS && int'(req.col) < sms_pkg::MAX_COLS) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    case (state_q)
      S_POPW:  mem_raddr = sms_pkg::addr_of(stk_rdata.ai, stk_rdata.aj);
      S_RA:    mem_raddr = sms_pkg::addr_of(rg_q.ai, rg_q.aj);
      S_RZ:    mem_raddr = sms_pkg::addr_of(rg_q.zi, rg_q.zj);
      S_CZ:    mem_raddr = sms_pkg::addr_of(rg_q.ai, rg_q.zj);
      S_C2:    mem_raddr = sms_pkg::addr_of(rg_q.zi, rg_q.aj);
      S_C3:    mem_raddr = sms_pkg::addr_of(mi, mj);
      default: mem_raddr = '0;
    endcase
  end

  always_comb begin
    stk_we    = 1'b0;
    stk_wdata = diag_rg;
    stk_raddr = lvl_dec[sms_pkg::SP_W-1:0];
    case (state_q)
      S_PU1: begin
        stk_we = !stk_full;
      end
      S_PU2: begin
        stk_we    = !stk_full && ll_ok;
        stk_wdata = ll_rg;
      end
      S_PU3: begin
        stk_we    = !stk_full && ur_ok;
        stk_wdata = ur_rg;
      end
      default: ;
    endcase
  end

  sms_ram #(
    .WIDTH (sms_pkg::DATA_W),
    .DEPTH (sms_pkg::MAX_ROWS * sms_pkg::MAX_COLS)
  ) u_matrix (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (req.value),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  sms_ram #(
    .WIDTH ($bits(sms_pkg::region_t)),
    .DEPTH (sms_pkg::STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (level_q[sms_pkg::SP_W-1:0]),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      level_q     <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_found_q <= 1'b0;
      lt_q        <= 1'b0;
      tgt_q       <= '0;
      a_q         <= '0;
      rg_q        <= '0;
    end else begin
      if (res.valid && res.ready && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept && req.cmd == sms_pkg::CMD_QUERY) begin
            tgt_q   <= req.target;
            rg_q    <= '{ai: '0, aj: '0, zi: last_row(cfg_i.row_count),
                         zj: last_col(cfg_i.col_count)};
            level_q <= '0;
            state_q <= S_RA;
          end
        end
        S_POP: begin
          if (level_q == '0) begin
            found_q <= 1'b0;
            state_q <= S_DONE;
          end else begin
            level_q <= lvl_dec;
            state_q <= S_POPW;
          end
        end
        S_POPW: begin
          rg_q    <= stk_rdata;
          state_q <= S_RZ;
        end
        S_RA: state_q <= S_RZ;
        S_RZ: begin
          a_q     <= rv;
          state_q <= S_CZ;
        end
        S_CZ: begin
          if (a_q == rv) begin
            if (tgt_q == a_q) begin
              found_q <= 1'b1;
              state_q <= S_DONE;
            end else begin
              state_q <= S_POP;
            end
          end else if (tgt_q == a_q || tgt_q == rv) begin
            found_q <= 1'b1;
            state_q <= S_DONE;
          end else if (tgt_q < a_q || tgt_q > rv) begin
            state_q <= S_POP;
          end else begin
            state_q <= S_C2;
          end
        end
        S_C2: begin
          if (tgt_q == rv) begin
            found_q <= 1'b1;
            state_q <= S_DONE;
          end else begin
            state_q <= S_C3;
          end
        end
        S_C3: begin
          if (tgt_q == rv) begin
            found_q <= 1'b1;
            state_q <= S_DONE;
          end else if (small_rg) begin
            state_q <= S_POP;
          end else begin
            state_q <= S_CM;
          end
        end
        S_CM: begin
          if (tgt_q == rv) begin
            found_q <= 1'b1;
            state_q <= S_DONE;
          end else begin
            lt_q    <= (tgt_q < rv);
            state_q <= S_PU1;
          end
        end
        S_PU1: begin
          if (stk_we) level_q <= level_q + 1'b1;
          state_q <= S_PU2;
        end
        S_PU2: begin
          if (stk_we) level_q <= level_q + 1'b1;
          state_q <= S_PU3;
        end
        S_PU3: begin
          if (stk_we) level_q <= level_q + 1'b1;
          state_q <= S_POP;
        end
        S_DONE: begin
          if (!out_valid_q || res.ready) begin
            out_valid_q <= 1'b1;
            out_found_q <= found_q;
            level_q     <= '0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/sorted_matrix_search_top.sv
// Sorted matrix search, top level: APB registers, request/result channels.
// Depends on sms_pkg, sms_if, sms_ram, sms_cfg, sms_search and the defines header.
//
// Holds a 64 x 64 matrix of signed 32-bit entries in a single-port-read RAM and
// answers whether a target occurs in the active row_count x col_count region,
// assuming rows and columns ascend. A load request writes one entry. A query walks
// regions by quadrant elimination, reading the matrix RAM through its registered
// read port: a region is dropped when its corners rule the target out or when it
// is a small leaf, and is otherwise split, with up to three subregions pushed onto
// a region stack held in a second RAM (the first region is not popped; a pop of the
// empty stack ends the query as not found). The result waits in an output register;
// load requests keep being taken while it waits, and a following query holds at its
// end until the register is free. There is no clearing pass: entries not loaded
// since reset read back as undefined.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_matrix_search_top_defines.svh"
module sorted_matrix_search_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [sms_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [sms_pkg::PDATA_W-1:0]  pwdata,
  output logic      [sms_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready,
  sms_in_if.sink                            req_i,
  sms_out_if.source                         res_o
);

  sms_pkg::cfg_t    cfg;
  sms_pkg::status_t stat;

  sms_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sms_search u_search (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .req    (req_i),
    .res    (res_o),
    .stat_o (stat)
  );

  `SMS_ASSERT(a_level_bound, stat.level <= sms_pkg::LVL_W'(sms_pkg::STACK_DEPTH))
  `SMS_ASSERT_NEXT(a_query_busy, req_i.valid && req_i.ready && req_i.cmd == sms_pkg::CMD_QUERY, stat.busy)
  `SMS_ASSERT(a_result_after_query, $rose(res_o.valid) |-> $past(stat.busy))

endmodule
`default_nettype wire
